[sv/dsd_pkg.sv]
package dsd_pkg;

  // field widths
  localparam int CW = 16;
  localparam int RIW = 14;

  // refraction index register
  localparam logic [RIW-1:0] RI_RESET = 14'd6144;
  localparam logic [RIW-1:0] RI_MIN = 14'd4096;
  localparam logic REG_RI = 1'b0;

  // pipeline depth: register 0 takes the transaction, register NST-1 drives the result
  localparam int NST = 62;
  localparam int LATENCY = 62;

  // step numbers of the pipeline (step k feeds register k+1)
  localparam int K_SQR = 0;   // squares and d*n
  localparam int K_SUM = 1;   // length squared, dot(d,n), square root setup
  localparam int K_SQ1 = 2;   // first square root, 16 steps
  localparam int K_RP = 2;    // dot(d,n) * n
  localparam int K_RV = 3;    // mirror reflection
  localparam int K_DV = 18;   // divider setup
  localparam int K_DIV = 19;  // divider, 15 steps
  localparam int K_UQ = 34;   // signed normalized direction
  localparam int K_UN = 35;   // u*n
  localparam int K_CS = 36;   // cosine, side
  localparam int K_ET = 37;   // eta, dt, c
  localparam int K_PR = 38;   // dt^2, eta^2, x, t
  localparam int K_P1 = 39;   // first of four fifth power steps, eta*t
  localparam int K_ES = 40;   // eta^2 * s, rounding of eta*t
  localparam int K_D28 = 41;  // radicand
  localparam int K_OK = 42;   // refraction test, second square root setup
  localparam int K_SQ2 = 43;  // second square root, 16 steps
  localparam int K_RF = 43;   // reflectance
  localparam int K_CMP = 44;  // reflect decision
  localparam int K_MQ = 59;   // m * sqrt
  localparam int K_FN = 60;   // final select and saturation

  typedef struct {
    logic signed [15:0] d [3];
    logic signed [15:0] n [3];
    logic [15:0] rf;
    logic [31:0] sqr [3];
    logic signed [31:0] prd [3];
    logic signed [31:0] dn;
    logic [31:0] xs;
    logic [19:0] rem;
    logic [15:0] root;
    logic [15:0] len;
    logic [31:0] drem [3];
    logic [14:0] q [3];
    logic neg [3];
    logic signed [15:0] u [3];
    logic signed [47:0] rp [3];
    logic signed [20:0] rv [3];
    logic signed [15:0] cosn;
    logic leave;
    logic signed [16:0] eta;
    logic signed [15:0] dt;
    logic signed [18:0] c;
    logic signed [18:0] x;
    logic [28:0] dt2;
    logic [31:0] eta2;
    logic [28:0] s;
    logic signed [30:0] t [3];
    logic signed [47:0] et [3];
    logic signed [32:0] rt [3];
    logic [60:0] pes;
    logic signed [34:0] d28;
    logic ok;
    logic signed [25:0] p;
    logic signed [28:0] refl;
    logic reflect;
    logic signed [30:0] msq [3];
    logic signed [15:0] o [3];
  } item_t;

endpackage

[sv/dielectric_scatter_direction.sv]
// channel      | signals                                          | direction
// -------------+--------------------------------------------------+----------
// ray in       | start, busy, dir_*, normal_*, random_fraction    | in/out
// scatter out  | done, out_x, out_y, out_z, chose_reflection      | out
// config       | psel, penable, pwrite, paddr, pwdata, prdata, pready | in/out
//
// a transaction enters on any cycle with start high and busy low; one per cycle
// its result shows on done once through pipe[0] to pipe[NST-1], a depth set by
// two 16-step square roots and a 15-step divider laid out as pipeline stages
// reset, and any write of refraction_index, holds busy high while
// a serial divider derives the entering index and the normal reflectance
// the pipeline never stalls: the receiver takes every result
module dielectric_scatter_direction (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [15:0] random_fraction,
  output logic done,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic chose_reflection,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_ETA_LD = 3'd1;
  localparam logic [2:0] C_ETA = 3'd2;
  localparam logic [2:0] C_R0_LD = 3'd3;
  localparam logic [2:0] C_R0 = 3'd4;
  localparam logic [2:0] C_SQ = 3'd5;

  logic [13:0] ri_raw;
  logic [13:0] ri_eff;
  logic cfg_wr;
  logic [2:0] cst;
  logic [4:0] dcnt;
  logic [15:0] drm;
  logic [29:0] dqo;
  logic [15:0] dden;
  logic [16:0] dsh;
  logic dge;
  logic [15:0] eta_in;
  logic [12:0] r0sq;
  logic [14:0] omr0;
  logic [27:0] r0p;
  logic [28:0] r0r;
  logic accept;
  dsd_pkg::item_t in_item;
  dsd_pkg::item_t pipe [dsd_pkg::NST];
  logic vld [dsd_pkg::NST];

  // one pipeline step, chosen by its constant step number
  function automatic dsd_pkg::item_t advance(input int k, input dsd_pkg::item_t a,
      input logic [13:0] ri, input logic [15:0] etai, input logic [12:0] r0s,
      input logic [14:0] om);
    dsd_pkg::item_t b;
    logic signed [31:0] m32;
    logic [32:0] ul;
    logic signed [32:0] acc;
    logic [19:0] rsh;
    logic [17:0] trial;
    logic signed [47:0] w48;
    logic signed [16:0] mag;
    logic [31:0] sub;
    logic [3:0] qb;
    logic signed [30:0] rc;
    logic signed [33:0] e34;
    logic signed [43:0] pp;
    logic [60:0] w61;
    logic signed [41:0] rp2;
    logic signed [15:0] m;
    logic signed [33:0] v;
    logic signed [20:0] sel;
    b = a;
    // squares and d*n
    if (k == dsd_pkg::K_SQR) begin
      for (int i = 0; i < 3; i++) begin
        m32 = a.d[i] * a.d[i];
        b.sqr[i] = m32;
        b.prd[i] = a.d[i] * a.n[i];
      end
    end
    // length squared, dot product and square root setup
    if (k == dsd_pkg::K_SUM) begin
      ul = {1'b0, a.sqr[0]} + {1'b0, a.sqr[1]} + {1'b0, a.sqr[2]};
      acc = a.prd[0] + a.prd[1] + a.prd[2];
      b.dn = acc[31:0];
      b.xs = ul[31:0];
      b.rem = '0;
      b.root = '0;
    end
    // one digit of a square root
    if ((k >= dsd_pkg::K_SQ1 && k < dsd_pkg::K_SQ1 + 16) ||
        (k >= dsd_pkg::K_SQ2 && k < dsd_pkg::K_SQ2 + 16)) begin
      rsh = {a.rem[17:0], a.xs[31:30]};
      trial = {a.root, 2'b01};
      if (rsh >= {2'b00, trial}) begin
        b.rem = rsh - {2'b00, trial};
        b.root = {a.root[14:0], 1'b1};
      end else begin
        b.rem = rsh;
        b.root = {a.root[14:0], 1'b0};
      end
      b.xs = {a.xs[29:0], 2'b00};
    end
    // mirror reflection
    if (k == dsd_pkg::K_RP) begin
      for (int i = 0; i < 3; i++) b.rp[i] = a.dn * a.n[i];
    end
    if (k == dsd_pkg::K_RV) begin
      for (int i = 0; i < 3; i++) begin
        w48 = (a.rp[i] + 48'sd67108864) >>> 27;
        b.rv[i] = a.d[i] - $signed(w48[20:0]);
      end
    end
    // divider setup: numerator and sign per lane
    if (k == dsd_pkg::K_DV) begin
      b.len = a.root;
      for (int i = 0; i < 3; i++) begin
        b.neg[i] = a.d[i][15];
        mag = a.d[i][15] ? -a.d[i] : a.d[i];
        b.drem[i] = {1'b0, mag[15:0], 15'b0} +
                    (a.d[i][15] ? ({16'b0, a.root} - 32'd1) : {16'b0, a.root});
        b.q[i] = '0;
      end
    end
    // one quotient bit
    if (k >= dsd_pkg::K_DIV && k < dsd_pkg::K_DIV + 15) begin
      qb = 4'(14 - (k - dsd_pkg::K_DIV));
      sub = {15'b0, a.len, 1'b0} << qb;
      for (int i = 0; i < 3; i++) begin
        if (a.drem[i] >= sub) begin
          b.drem[i] = a.drem[i] - sub;
          b.q[i][qb] = 1'b1;
        end
      end
    end
    if (k == dsd_pkg::K_UQ) begin
      for (int i = 0; i < 3; i++) begin
        if (a.len == 16'd0) b.u[i] = '0;
        else if (a.neg[i]) b.u[i] = -$signed({1'b0, a.q[i]});
        else b.u[i] = $signed({1'b0, a.q[i]});
      end
    end
    if (k == dsd_pkg::K_UN) begin
      for (int i = 0; i < 3; i++) b.prd[i] = a.u[i] * a.n[i];
    end
    // clamped cosine and side of the surface
    if (k == dsd_pkg::K_CS) begin
      acc = a.prd[0] + a.prd[1] + a.prd[2];
      acc = (acc + 33'sd8192) >>> 14;
      if (acc > 33'sd16384) b.cosn = 16'sd16384;
      else if (acc < -33'sd16384) b.cosn = -16'sd16384;
      else b.cosn = acc[15:0];
      b.leave = a.dn > 32'sd0;
    end
    if (k == dsd_pkg::K_ET) begin
      if (a.leave) begin
        b.eta = $signed({1'b0, ri, 2'b00});
        b.dt = -a.cosn;
        rc = $signed({1'b0, ri}) * a.cosn;
        rc = (rc + 31'sd2048) >>> 12;
        b.c = rc[18:0];
      end else begin
        b.eta = $signed({1'b0, etai});
        b.dt = a.cosn;
        b.c = -$signed({{3{a.cosn[15]}}, a.cosn});
      end
    end
    if (k == dsd_pkg::K_PR) begin
      m32 = a.dt * a.dt;
      b.dt2 = m32[28:0];
      e34 = a.eta * a.eta;
      b.eta2 = e34[31:0];
      b.x = 19'sd16384 - a.c;
      for (int i = 0; i < 3; i++) begin
        m = a.leave ? -a.n[i] : a.n[i];
        b.t[i] = a.u[i] * 31'sd16384 - m * a.dt;
      end
    end
    if (k == dsd_pkg::K_P1) begin
      b.s = 29'd268435456 - a.dt2;
      for (int i = 0; i < 3; i++) b.et[i] = a.eta * a.t[i];
    end
    // fifth power of x, four rounded steps
    if (k >= dsd_pkg::K_P1 && k < dsd_pkg::K_P1 + 4) begin
      if (k == dsd_pkg::K_P1) pp = a.x * a.x;
      else pp = a.p * a.x;
      pp = (pp + 44'sd8192) >>> 14;
      b.p = pp[25:0];
    end
    if (k == dsd_pkg::K_ES) begin
      b.pes = a.eta2 * a.s;
      for (int i = 0; i < 3; i++) begin
        w48 = (a.et[i] + 48'sd8192) >>> 14;
        b.rt[i] = w48[32:0];
      end
    end
    if (k == dsd_pkg::K_D28) begin
      w61 = (a.pes + 61'd134217728) >> 28;
      b.d28 = 35'sd268435456 - $signed({2'b00, w61[32:0]});
    end
    if (k == dsd_pkg::K_OK) begin
      b.ok = a.d28 > 35'sd0;
      b.xs = (a.d28 > 35'sd0) ? a.d28[31:0] : 32'd0;
      b.rem = '0;
      b.root = '0;
    end
    // schlick reflectance
    if (k == dsd_pkg::K_RF) begin
      rp2 = $signed({1'b0, om}) * a.p;
      rp2 = (rp2 + 42'sd8192) >>> 14;
      b.refl = $signed({16'b0, r0s}) + rp2[28:0];
    end
    if (k == dsd_pkg::K_CMP) begin
      b.reflect = !a.ok || ($signed({15'b0, a.rf}) < $signed({a.refl, 2'b00}));
    end
    if (k == dsd_pkg::K_MQ) begin
      for (int i = 0; i < 3; i++) begin
        m = a.leave ? -a.n[i] : a.n[i];
        b.msq[i] = m * $signed({1'b0, a.root});
      end
    end
    // pick reflection or refraction, saturate
    if (k == dsd_pkg::K_FN) begin
      for (int i = 0; i < 3; i++) begin
        v = a.rt[i] - a.msq[i];
        v = (v + 34'sd8192) >>> 14;
        sel = a.reflect ? a.rv[i] : v[20:0];
        if (sel > 21'sd32767) b.o[i] = 16'sd32767;
        else if (sel < -21'sd32768) b.o[i] = -16'sd32768;
        else b.o[i] = sel[15:0];
      end
    end
    return b;
  endfunction

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dsd_pkg::REG_RI);
  assign prdata = (paddr[2] == dsd_pkg::REG_RI) ? {18'b0, ri_raw} : 32'd0;
  assign ri_eff = (ri_raw < dsd_pkg::RI_MIN) ? dsd_pkg::RI_MIN : ri_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      ri_raw <= dsd_pkg::RI_RESET;
    end else if (cfg_wr) begin
      ri_raw <= pwdata[13:0];
    end
  end

  // serial divider for the entering index and the normal reflectance
  assign dsh = {drm, dqo[29]};
  assign dge = dsh >= {1'b0, dden};
  assign r0p = dqo[13:0] * dqo[13:0];
  assign r0r = {1'b0, r0p} + 29'd8192;
  assign omr0 = 15'd16384 - {2'b00, r0sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_ETA_LD;
      dcnt <= '0;
    end else if (cfg_wr) begin
      cst <= C_ETA_LD;
    end else begin
      case (cst)
        C_ETA_LD: begin
          dcnt <= '0;
          cst <= C_ETA;
        end
        C_ETA: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd29) cst <= C_R0_LD;
        end
        C_R0_LD: begin
          dcnt <= '0;
          cst <= C_R0;
        end
        C_R0: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd29) cst <= C_SQ;
        end
        C_SQ: cst <= C_IDLE;
        default: cst <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cst)
      C_ETA_LD: begin
        dqo <= 30'd134217728 + {16'b0, ri_eff};
        dden <= {1'b0, ri_eff, 1'b0};
        drm <= '0;
      end
      C_R0_LD: begin
        eta_in <= dqo[15:0];
        dqo <= {1'b0, ri_eff - dsd_pkg::RI_MIN, 15'b0} + {16'b0, ri_eff} + 30'd4095;
        dden <= {1'b0, ri_eff, 1'b0} + 16'd8192;
        drm <= '0;
      end
      C_ETA, C_R0: begin
        drm <= dge ? 16'(dsh - {1'b0, dden}) : dsh[15:0];
        dqo <= {dqo[28:0], dge};
      end
      C_SQ: r0sq <= r0r[26:14];
      default: drm <= drm;
    endcase
  end

  assign busy = cst != C_IDLE;
  assign accept = start && !busy;

  // input register with the normal clamped to unit range
  always_comb begin
    in_item = '{default: '0};
    in_item.d[0] = dir_x;
    in_item.d[1] = dir_y;
    in_item.d[2] = dir_z;
    in_item.n[0] = (normal_x > 16'sd16384) ? 16'sd16384 :
                   (normal_x < -16'sd16384) ? -16'sd16384 : normal_x;
    in_item.n[1] = (normal_y > 16'sd16384) ? 16'sd16384 :
                   (normal_y < -16'sd16384) ? -16'sd16384 : normal_y;
    in_item.n[2] = (normal_z > 16'sd16384) ? 16'sd16384 :
                   (normal_z < -16'sd16384) ? -16'sd16384 : normal_z;
    in_item.rf = random_fraction;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= accept;
    pipe[0] <= in_item;
  end

  // pipeline stages
  for (genvar g = 0; g < dsd_pkg::NST - 1; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else vld[g+1] <= vld[g];
      pipe[g+1] <= advance(g, pipe[g], ri_eff, eta_in, r0sq, omr0);
    end
  end

  // result transaction
  assign done = vld[dsd_pkg::NST-1];
  assign out_x = pipe[dsd_pkg::NST-1].o[0];
  assign out_y = pipe[dsd_pkg::NST-1].o[1];
  assign out_z = pipe[dsd_pkg::NST-1].o[2];
  assign chose_reflection = pipe[dsd_pkg::NST-1].reflect;

endmodule

[sv/dsd_check.sv]
module dsd_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic signed [15:0] dir_x,
  input logic signed [15:0] dir_y,
  input logic signed [15:0] dir_z,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic [15:0] random_fraction,
  input logic done,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic chose_reflection,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic [2:0] paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic pready
);

  // reset starts the derived-constant computation
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // reset flushes the pipeline
  a_rst_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  // an index write recomputes the derived constants
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[2] == dsd_pkg::REG_RI)) |=> busy)
    else $error("busy low after index write");

  // every result traces back to an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, dsd_pkg::LATENCY))
    else $error("result without matching transaction");

endmodule

bind dielectric_scatter_direction dsd_check u_dsd_check (.*);
